FILE: hw/rtl/dfpmd_pkg.sv
// ----------------------------------------------------------------------------
// Decimal fixed-point multiply/divide package
// Word types, register codes and scale constants shared by the block.
// ----------------------------------------------------------------------------
package dfpmd_pkg;

    localparam int DIV_BITS = 64;

    localparam logic [1:0] REG_DECIMAL_PLACES = 2'd0;
    localparam logic [1:0] REG_UNSIGNED_MODE  = 2'd1;
    localparam logic [1:0] REG_PRECISION_MODE = 2'd2;

    localparam logic [1:0] PM_NARROW32 = 2'd0;
    localparam logic [1:0] PM_WIDE32   = 2'd1;
    localparam logic [1:0] PM_PRESCALE = 2'd2;
    localparam logic [1:0] PM_FULL64   = 2'd3;

    localparam logic [2:0] DP_RESET = 3'd2;

    // Reciprocals giving exact 32-bit division by ten (shift 35) and a hundred (shift 37).
    localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP100 = 32'h51EB_851F;

    typedef struct packed {
        logic               action;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] product_or_quotient;
        logic               divide_by_zero;
    } t_out_word;

    function automatic logic [13:0] scale_of(input logic [1:0] dpe);
        logic [13:0] s;
        case (dpe)
            2'd0:    s = 14'd10;
            2'd1:    s = 14'd100;
            2'd2:    s = 14'd1000;
            default: s = 14'd10000;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/decimal_fixed_point_mul_div.sv
// ----------------------------------------------------------------------------
// Decimal fixed-point multiply/divide
// Multiplies or divides decimal-scaled fixed-point words in four precision
// modes, signed or unsigned, with a fully pipelined radix-2 divider.
// ----------------------------------------------------------------------------
//  channel   valid        stall        word
//  input     i_in_valid   o_in_stall   i_in_word
//  output    o_out_valid  i_out_stall  o_out_word
//  config    APB write/read, registers at byte addresses 0, 4 and 8
//
// A word accepted at one edge passes through the 64 one-bit stages of the
// divider before it is loaded into the output register. One word may enter
// in every cycle while o_in_stall is low.
// Reset clears the valid bits and restores the configuration registers.
// A stalled output freezes the pipeline only once its last stage holds a word.
module decimal_fixed_point_mul_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dfpmd_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dfpmd_pkg::t_out_word o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import dfpmd_pkg::*;

    typedef struct packed {
        logic        div;
        logic        sa;
        logic        sb;
        logic        zero;
        logic [63:0] ma;
        logic [63:0] mb;
    } t_opnd;

    typedef struct packed {
        logic neg;
        logic zero;
        logic sneg;
        logic div;
    } t_side;

    logic [2:0] r_dp;
    logic       r_um;
    logic [1:0] r_pm;

    logic [1:0]  w_dpe;
    logic [13:0] w_scale;
    logic        w_w32;
    logic        w_m2;
    logic        w_en;
    logic        w_load_out;

    t_opnd       n_s1, r_s1, r_s2, r_s3, r_s4;
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [63:0] r_pa, r_pb;
    logic [31:0] w_pre_a, w_pre_b;
    logic [63:0] w_x, w_y;
    logic [63:0] r_ll, r_hl, r_lh;
    logic [63:0] r_prod;

    logic [63:0] w_val;
    logic [31:0] w_v32;
    logic        w_sgn, w_nneg;
    logic [63:0] w_num, w_den;

    logic [DIV_BITS:0] r_dv_v;
    logic [63:0]       r_dv_rem [0:DIV_BITS];
    logic [63:0]       r_dv_nq  [0:DIV_BITS];
    logic [63:0]       r_dv_den [0:DIV_BITS];
    t_side             r_dv_sd  [0:DIV_BITS];

    logic        r_vp;
    logic [63:0] r_mag;
    t_side       r_sp;
    logic [63:0] w_res, w_fin;

    logic      r_out_v;
    t_out_word r_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp <= DP_RESET;
            r_um <= 1'b0;
            r_pm <= PM_NARROW32;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_DECIMAL_PLACES: r_dp <= pwdata[2:0];
                REG_UNSIGNED_MODE:  r_um <= pwdata[0];
                REG_PRECISION_MODE: r_pm <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DECIMAL_PLACES: prdata = {29'b0, r_dp};
            REG_UNSIGNED_MODE:  prdata = {31'b0, r_um};
            REG_PRECISION_MODE: prdata = {30'b0, r_pm};
            default:            prdata = 32'b0;
        endcase
    end

    always_comb begin
        case (r_dp)
            3'd0, 3'd1: w_dpe = 2'd0;
            3'd2:       w_dpe = 2'd1;
            3'd3:       w_dpe = 2'd2;
            default:    w_dpe = 2'd3;
        endcase
    end

    assign w_scale = scale_of(w_dpe);
    assign w_w32   = (r_pm != PM_FULL64);
    assign w_m2    = (r_pm == PM_PRESCALE);

    assign w_load_out = !r_out_v || !i_out_stall;
    assign w_en       = w_load_out || !r_vp;
    assign o_in_stall = !w_en;

    always_comb begin
        logic [63:0] a, b;
        a = i_in_word.operand_a;
        b = i_in_word.operand_b;
        n_s1.div = i_in_word.action;
        if (w_w32) begin
            n_s1.sa   = !r_um && a[31];
            n_s1.sb   = !r_um && b[31];
            n_s1.ma   = {32'b0, n_s1.sa ? -a[31:0] : a[31:0]};
            n_s1.mb   = {32'b0, n_s1.sb ? -b[31:0] : b[31:0]};
            n_s1.zero = i_in_word.action && (b[31:0] == 32'b0);
        end else begin
            n_s1.sa   = !r_um && a[63];
            n_s1.sb   = !r_um && b[63];
            n_s1.ma   = n_s1.sa ? -a : a;
            n_s1.mb   = n_s1.sb ? -b : b;
            n_s1.zero = i_in_word.action && (b == 64'b0);
        end
    end

    always_comb begin
        w_pre_a = (w_dpe >= 2'd2) ? 32'(r_pa >> 37) : 32'(r_pa >> 35);
        if (w_dpe == 2'd0) begin
            w_pre_b = r_s2.mb[31:0];
        end else if (w_dpe == 2'd3) begin
            w_pre_b = 32'(r_pb >> 37);
        end else begin
            w_pre_b = 32'(r_pb >> 35);
        end
        if (r_s2.div) begin
            w_x = r_s2.ma;
            w_y = w_m2 ? 64'd1 : {50'b0, w_scale};
        end else if (w_m2) begin
            w_x = {32'b0, w_pre_a};
            w_y = {32'b0, w_pre_b};
        end else begin
            w_x = r_s2.ma;
            w_y = r_s2.mb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1   <= n_s1;
            r_s2   <= r_s1;
            r_pa   <= {32'b0, r_s1.ma[31:0]}
                      * {32'b0, (w_dpe >= 2'd2) ? RECIP100 : RECIP10};
            r_pb   <= {32'b0, r_s1.mb[31:0]}
                      * {32'b0, (w_dpe == 2'd3) ? RECIP100 : RECIP10};
            r_s3   <= r_s2;
            r_ll   <= {32'b0, w_x[31:0]} * {32'b0, w_y[31:0]};
            r_hl   <= {32'b0, w_x[63:32]} * {32'b0, w_y[31:0]};
            r_lh   <= {32'b0, w_x[31:0]} * {32'b0, w_y[63:32]};
            r_s4   <= r_s3;
            r_prod <= r_ll + {r_hl[31:0] + r_lh[31:0], 32'b0};
        end
    end

    always_comb begin
        w_sgn = r_s4.div ? r_s4.sa : (r_s4.sa ^ r_s4.sb);
        w_val = w_sgn ? -r_prod : r_prod;
        w_v32 = w_val[31:0];
        case (r_pm)
            PM_NARROW32: begin
                w_nneg = !r_um && w_v32[31];
                w_num  = {32'b0, w_nneg ? -w_v32 : w_v32};
            end
            PM_PRESCALE: begin
                w_nneg = w_sgn;
                w_num  = r_prod;
            end
            default: begin
                w_nneg = !r_um && w_val[63];
                w_num  = w_nneg ? -w_val : w_val;
            end
        endcase
        if (r_s4.div) begin
            w_den = r_s4.mb;
        end else begin
            w_den = w_m2 ? 64'd1 : {50'b0, w_scale};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem[0]     <= 64'b0;
            r_dv_nq[0]      <= w_num;
            r_dv_den[0]     <= w_den;
            r_dv_sd[0].neg  <= r_s4.div ? (w_nneg ^ r_s4.sb) : w_nneg;
            r_dv_sd[0].zero <= r_s4.zero;
            r_dv_sd[0].sneg <= r_s4.sa;
            r_dv_sd[0].div  <= r_s4.div;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        logic [64:0] w_sh;
        logic        w_ge;

        assign w_sh = {r_dv_rem[k], r_dv_nq[k][63]};
        assign w_ge = (w_sh >= {1'b0, r_dv_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k+1] <= w_ge ? 64'(w_sh - {1'b0, r_dv_den[k]}) : w_sh[63:0];
                r_dv_nq[k+1]  <= {r_dv_nq[k][62:0], w_ge};
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_sd[k+1]  <= r_dv_sd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_en) begin
            r_vp <= r_dv_v[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sp <= r_dv_sd[DIV_BITS];
            if (r_dv_sd[DIV_BITS].div && w_m2) begin
                r_mag <= {32'b0, r_dv_nq[DIV_BITS][31:0]} * {50'b0, w_scale};
            end else begin
                r_mag <= r_dv_nq[DIV_BITS];
            end
        end
    end

    always_comb begin
        w_res = r_sp.neg ? -r_mag : r_mag;
        if (r_sp.zero) begin
            if (w_w32) begin
                w_fin = r_sp.sneg ? 64'hFFFF_FFFF_8000_0000 : 64'h0000_0000_7FFF_FFFF;
            end else if (r_um) begin
                w_fin = 64'hFFFF_FFFF_FFFF_FFFF;
            end else begin
                w_fin = r_sp.sneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end
        end else if (w_w32) begin
            w_fin = r_um ? {32'b0, w_res[31:0]} : {{32{w_res[31]}}, w_res[31:0]};
        end else begin
            w_fin = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load_out) begin
            r_out_v <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.product_or_quotient <= w_fin;
            r_out.divide_by_zero      <= r_sp.zero;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

endmodule

FILE: dv/decimal_fixed_point_mul_div_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal fixed-point multiply/divide testbench
// Drives directed and random words through the block across all decimal
// places, both signedness modes and all four precision modes, predicts each result and
// checks it field by field against the output words in order.
// ----------------------------------------------------------------------------
module decimal_fixed_point_mul_div_tb;
    import dfpmd_pkg::*;

    localparam int LATENCY   = 71;
    localparam int CYCLE_MAX = 900000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;
    logic      psel;
    logic      penable;
    logic      pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    decimal_fixed_point_mul_div uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [2:0] cfg_places;
    logic       cfg_unsigned;
    logic [1:0] cfg_precision;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        error_count;
    int        checked_count;
    int        cycle_count;
    bit        calm;
    bit        in_taken;
    int        send_gap;
    int        recv_gap;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] sign32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Truncating signed divide that wraps the minimum divided by minus one.
    function automatic logic [63:0] sdiv_wrap(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
        if (b == -64'sd1) return 64'd0 - a;
        return a / b;
    endfunction

    function automatic t_out_word scaled_result(input t_in_word w);
        t_out_word r;
        logic [2:0] dp;
        logic [63:0] s, f1, f2, ua, ub, res;
        logic signed [63:0] sa, sb, ss;
        dp = cfg_places;
        if (dp < 3'd1) dp = 3'd1;
        if (dp > 3'd4) dp = 3'd4;
        s  = (dp == 1) ? 64'd10 : (dp == 2) ? 64'd100 : (dp == 3) ? 64'd1000 : 64'd10000;
        f1 = (dp <= 2) ? 64'd10 : 64'd100;
        f2 = (dp == 1) ? 64'd1 : (dp == 4) ? 64'd100 : 64'd10;
        ss = s;
        res = '0;
        r.divide_by_zero = 1'b0;
        if (cfg_precision == PM_FULL64) begin
            ua = w.operand_a;
            ub = w.operand_b;
            sa = w.operand_a;
            sb = w.operand_b;
            if (cfg_unsigned) begin
                if (!w.action) res = (ua * ub) / s;
                else if (ub == 0) begin
                    r.divide_by_zero = 1'b1;
                    res = '1;
                end else res = (ua * s) / ub;
            end else begin
                if (!w.action) res = $signed(ua * ub) / ss;
                else if (sb == 0) begin
                    r.divide_by_zero = 1'b1;
                    res = sa < 0 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end else res = sdiv_wrap($signed(ua * s), sb);
            end
        end else if (cfg_unsigned) begin
            ua = {32'd0, w.operand_a[31:0]};
            ub = {32'd0, w.operand_b[31:0]};
            if (!w.action) begin
                if (cfg_precision == PM_NARROW32) res = ((ua * ub) & 64'hFFFF_FFFF) / s;
                else if (cfg_precision == PM_WIDE32) res = (ua * ub) / s;
                else res = (ua / f1) * (ub / f2);
            end else if (ub == 0) begin
                r.divide_by_zero = 1'b1;
                res = 64'h7FFF_FFFF;
            end else begin
                if (cfg_precision == PM_NARROW32) res = ((ua * s) & 64'hFFFF_FFFF) / ub;
                else if (cfg_precision == PM_WIDE32) res = (ua * s) / ub;
                else res = (ua / ub) * s;
            end
            res = {32'd0, res[31:0]};
        end else begin
            sa = sign32(w.operand_a);
            sb = sign32(w.operand_b);
            if (!w.action) begin
                if (cfg_precision == PM_NARROW32) res = $signed(sign32(sa * sb)) / ss;
                else if (cfg_precision == PM_WIDE32) res = (sa * sb) / ss;
                else res = (sa / $signed(f1)) * (sb / $signed(f2));
            end else if (sb == 0) begin
                r.divide_by_zero = 1'b1;
                res = sa < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
            end else begin
                if (cfg_precision == PM_NARROW32) res = sdiv_wrap(sign32(sa * ss), sb);
                else if (cfg_precision == PM_WIDE32) res = sdiv_wrap(sa * ss, sb);
                else res = (sa / sb) * ss;
            end
            res = sign32(res);
        end
        r.product_or_quotient = res;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("Mismatch in %s at word %0d: got %h, expected %h",
                 what, checked_count, got, want);
    endtask

    // Driver: one word per accepted handshake, with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (in_taken) void'(pending_words.pop_front());
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pending_words[0];
                    if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 7);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 7);
            end
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge i_clk) begin
        t_out_word want;
        cycle_count++;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) expected_words.push_back(scaled_result(i_in_word));
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    error_count++;
                    $display("Unexpected output word %h", o_out_word);
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_word.product_or_quotient !== want.product_or_quotient)
                        report_mismatch("product_or_quotient",
                                        o_out_word.product_or_quotient,
                                        want.product_or_quotient);
                    if (o_out_word.divide_by_zero !== want.divide_by_zero)
                        report_mismatch("divide_by_zero",
                                        {63'd0, o_out_word.divide_by_zero},
                                        {63'd0, want.divide_by_zero});
                    checked_count++;
                end
            end
        end
        if (cycle_count > CYCLE_MAX) begin
            $display("Timeout with %0d words outstanding", expected_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_DECIMAL_PLACES: cfg_places    = value[2:0];
            REG_UNSIGNED_MODE:  cfg_unsigned  = value[0];
            default:            cfg_precision = value[1:0];
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic add_word(input logic act, input logic [63:0] a, input logic [63:0] b);
        t_in_word w;
        w.action    = act;
        w.operand_a = a;
        w.operand_b = b;
        pending_words.push_back(w);
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 2000);
            1: v = -$signed({32'd0, $urandom_range(0, 2000)});
            2: v = sign32({32'd0, $urandom});
            3: v = {32'd0, $urandom};
            4: v = $urandom_range(0, 3) == 0 ? 64'd0 : v;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        int phase;
        logic [63:0] edges[8];
        edges = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF,
                  64'h8000_0000, 64'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'h8000_0000_0000_0000};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        checked_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        in_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        cfg_places = DP_RESET;
        cfg_unsigned = 1'b0;
        cfg_precision = PM_NARROW32;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: extremes, zero denominators and minimum by minus one.
        for (int i = 0; i < 8; i++) add_word(i[0], edges[i], edges[7 - i]);
        add_word(1'b1, 64'h8000_0000, 64'hFFFF_FFFF);
        add_word(1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'd0);
        add_word(1'b1, 64'd1234, 64'd0);
        add_word(1'b0, 64'd12345, 64'd250);
        drain();

        for (phase = 0; phase < 64; phase++) begin
            apb_write(REG_DECIMAL_PLACES, phase < 16 ? phase[2:0] : $urandom_range(0, 7));
            apb_write(REG_UNSIGNED_MODE, phase[3]);
            apb_write(REG_PRECISION_MODE, phase[5:4] ^ phase[1:0]);
            if (phase >= 56) calm = 1'b1;
            add_word(1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
            add_word(1'b1, 64'hFFFF_FFFF_8000_0000, 64'd0);
            for (int k = 0; k < 28; k++)
                add_word($urandom_range(0, 1), rand_operand(), rand_operand());
            drain();
        end

        $display("Checked %0d words over 64 register settings, with all places,",
                 checked_count);
        $display("both signedness modes and all four precision modes.");
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
